@@ hw/rtl/ukt_pkg.sv @@
// Shared types and constants of the unique-key record table.
// Depends on nothing; used by the channel interfaces and the core.
`default_nettype none

package ukt_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 31;
    localparam int GRP_W    = 2;
    localparam int HND_W    = 32;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LIST   = 2'd2
    } func_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_REMOVED   = 3'd3,
        STATUS_NOT_FOUND = 3'd4,
        STATUS_LISTED    = 3'd5,
        STATUS_NO_MATCH  = 3'd6
    } status_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_e_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [GRP_W-1:0] group;
        logic [HND_W-1:0] name_ref;
        logic [HND_W-1:0] surname_ref;
    } entry_t;

    typedef struct packed {
        status_e_t        status;
        logic [KEY_W-1:0] out_key;
        logic [GRP_W-1:0] out_group;
        logic [HND_W-1:0] out_name_handle;
        logic [HND_W-1:0] out_surname_handle;
        logic [FILL_W-1:0] fill_level;
        logic             last;
    } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ukt_cmd_if.sv @@
// Request channel of the record table: valid/ready plus one command item.
// Depends on ukt_pkg for field widths.
`default_nettype none

interface ukt_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [ukt_pkg::FUNC_W-1:0]   func;
    logic [ukt_pkg::KEY_W-1:0]    key;
    logic [ukt_pkg::GRP_W-1:0]    year_group;
    logic [ukt_pkg::HND_W-1:0]    name_handle;
    logic [ukt_pkg::HND_W-1:0]    surname_handle;

    modport source (
        output valid, func, key, year_group, name_handle, surname_handle,
        input  ready
    );
    modport sink (
        input  valid, func, key, year_group, name_handle, surname_handle,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/ukt_rsp_if.sv @@
// Result channel of the record table: valid/ready plus one result item.
// Depends on ukt_pkg for field widths.
`default_nettype none

interface ukt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ukt_pkg::STATUS_W-1:0]  status;
    logic [ukt_pkg::KEY_W-1:0]     out_key;
    logic [ukt_pkg::GRP_W-1:0]     out_group;
    logic [ukt_pkg::HND_W-1:0]     out_name_handle;
    logic [ukt_pkg::HND_W-1:0]     out_surname_handle;
    logic [ukt_pkg::FILL_W-1:0]    fill_level;
    logic                          last;

    modport source (
        output valid, status, out_key, out_group, out_name_handle,
               out_surname_handle, fill_level, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_key, out_group, out_name_handle,
               out_surname_handle, fill_level, last,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/unique_key_table_with_compaction_core.sv @@
// Unique-key record table with order-preserving compaction on remove.
// Sequence: a read and a compare state per examined entry, a read and a write state
// per entry moved down on a remove, then a finishing state; a result is visible
// the cycle after it forms. Throughput: one item at a time, and a result may wait
// on rsp.ready; set by the single registered read port of the memory.
// Reset: clears fill count and control; record memory is not cleared.
`default_nettype none

module unique_key_table_with_compaction_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ukt_cmd_if.sink     cmd,
    ukt_rsp_if.source   rsp
);

    localparam int ADDR_W = ukt_pkg::ADDR_W;
    localparam int CNT_W  = ukt_pkg::CNT_W;

    // Record memory: one write and one registered read per cycle.
    ukt_pkg::entry_t mem [ukt_pkg::DEPTH];
    ukt_pkg::entry_t mem_rdata_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    ukt_pkg::entry_t   wr_data;

    // Sequencer and held command.
    ukt_pkg::state_e_t state_reg, state_next;
    logic [ukt_pkg::FUNC_W-1:0] op_reg, op_next;
    ukt_pkg::entry_t   cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;

    // A listed entry waits here until we know whether it is the last one.
    ukt_pkg::entry_t   pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;

    // Output register.
    ukt_pkg::rsp_t     out_reg;
    logic              out_valid_reg;

    logic              slot_free;
    logic              emit;
    ukt_pkg::rsp_t     emit_data;
    logic [CNT_W-1:0]  idx_inc;
    logic [CNT_W-1:0]  idx_inc2;
    logic              at_end;
    logic              shift_end;
    logic              key_hit;
    logic              grp_hit;
    logic              list_stall;
    logic              is_full;
    logic              do_insert;

    function automatic logic [CNT_W-1:0] idx_inc_count(input logic [CNT_W-1:0] n);
        return n + CNT_W'(1);
    endfunction

    assign slot_free  = !out_valid_reg || rsp.ready;
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign idx_inc2   = idx_reg + CNT_W'(2);
    assign at_end     = (idx_inc == count_reg);
    assign shift_end  = (idx_inc2 == count_reg);
    assign key_hit    = (mem_rdata_reg.key == cmd_reg.key);
    assign grp_hit    = (mem_rdata_reg.group == cmd_reg.group);
    assign is_full    = (count_reg == CNT_W'(ukt_pkg::DEPTH));
    // A second match cannot take over the pending slot until the older one goes out.
    assign list_stall = (op_reg == ukt_pkg::FUNC_LIST) && grp_hit && pend_valid_reg
                        && !slot_free;
    assign do_insert  = (op_reg == ukt_pkg::FUNC_INSERT) && !found_reg && !is_full;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_rdata_reg <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ukt_pkg::ST_IDLE:
            begin
                if (cmd.valid && (cmd.func == ukt_pkg::FUNC_INSERT
                                  || cmd.func == ukt_pkg::FUNC_REMOVE
                                  || cmd.func == ukt_pkg::FUNC_LIST))
                begin
                    state_next = (count_reg == '0) ? ukt_pkg::ST_DONE : ukt_pkg::ST_RD;
                end
            end
            ukt_pkg::ST_RD:
            begin
                state_next = ukt_pkg::ST_EVAL;
            end
            ukt_pkg::ST_EVAL:
            begin
                case (op_reg)
                    ukt_pkg::FUNC_INSERT:
                    begin
                        if (key_hit || at_end)
                            state_next = ukt_pkg::ST_DONE;
                        else
                            state_next = ukt_pkg::ST_RD;
                    end
                    ukt_pkg::FUNC_REMOVE:
                    begin
                        if (at_end)
                            state_next = ukt_pkg::ST_DONE;
                        else if (key_hit)
                            state_next = ukt_pkg::ST_SHIFT_RD;
                        else
                            state_next = ukt_pkg::ST_RD;
                    end
                    default:
                    begin
                        if (list_stall)
                            state_next = ukt_pkg::ST_EVAL;
                        else if (at_end)
                            state_next = ukt_pkg::ST_DONE;
                        else
                            state_next = ukt_pkg::ST_RD;
                    end
                endcase
            end
            ukt_pkg::ST_SHIFT_RD:
            begin
                state_next = ukt_pkg::ST_SHIFT_WR;
            end
            ukt_pkg::ST_SHIFT_WR:
            begin
                state_next = shift_end ? ukt_pkg::ST_DONE : ukt_pkg::ST_SHIFT_RD;
            end
            ukt_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = ukt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ukt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: memory controls and result formation.
    always_comb
    begin
        emit      = 1'b0;
        emit_data = '0;
        wr_en     = 1'b0;
        wr_addr   = count_reg[ADDR_W-1:0];
        wr_data   = cmd_reg;
        rd_addr   = idx_reg[ADDR_W-1:0];
        emit_data.fill_level = ukt_pkg::FILL_W'(count_reg);
        unique case (state_reg)
            ukt_pkg::ST_EVAL:
            begin
                // Flush the older pending match; it is not the last one.
                if (op_reg == ukt_pkg::FUNC_LIST && grp_hit && pend_valid_reg)
                begin
                    emit                         = slot_free;
                    emit_data.status             = ukt_pkg::STATUS_LISTED;
                    emit_data.out_key            = pend_reg.key;
                    emit_data.out_group          = pend_reg.group;
                    emit_data.out_name_handle    = pend_reg.name_ref;
                    emit_data.out_surname_handle = pend_reg.surname_ref;
                end
            end
            ukt_pkg::ST_SHIFT_RD:
            begin
                rd_addr = idx_inc[ADDR_W-1:0];
            end
            ukt_pkg::ST_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[ADDR_W-1:0];
                wr_data = mem_rdata_reg;
            end
            ukt_pkg::ST_DONE:
            begin
                emit           = slot_free;
                emit_data.last = 1'b1;
                case (op_reg)
                    ukt_pkg::FUNC_INSERT:
                    begin
                        if (found_reg)
                            emit_data.status = ukt_pkg::STATUS_DUPLICATE;
                        else if (is_full)
                            emit_data.status = ukt_pkg::STATUS_FULL;
                        else
                        begin
                            emit_data.status     = ukt_pkg::STATUS_INSERTED;
                            emit_data.fill_level = ukt_pkg::FILL_W'(idx_inc_count(count_reg));
                        end
                        wr_en = slot_free && do_insert;
                    end
                    ukt_pkg::FUNC_REMOVE:
                    begin
                        emit_data.status = found_reg ? ukt_pkg::STATUS_REMOVED
                                                     : ukt_pkg::STATUS_NOT_FOUND;
                    end
                    default:
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_data.status             = ukt_pkg::STATUS_LISTED;
                            emit_data.out_key            = pend_reg.key;
                            emit_data.out_group          = pend_reg.group;
                            emit_data.out_name_handle    = pend_reg.name_ref;
                            emit_data.out_surname_handle = pend_reg.surname_ref;
                        end
                        else
                        begin
                            emit_data.status = ukt_pkg::STATUS_NO_MATCH;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        op_next         = op_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        case (state_reg)
            ukt_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next              = cmd.func;
                    cmd_next.key         = cmd.key;
                    cmd_next.group       = cmd.year_group;
                    cmd_next.name_ref    = cmd.name_handle;
                    cmd_next.surname_ref = cmd.surname_handle;
                    idx_next             = '0;
                    found_next           = 1'b0;
                    pend_valid_next      = 1'b0;
                end
            end
            ukt_pkg::ST_EVAL:
            begin
                case (op_reg)
                    ukt_pkg::FUNC_INSERT:
                    begin
                        if (key_hit)
                            found_next = 1'b1;
                        else
                            idx_next = idx_inc;
                    end
                    ukt_pkg::FUNC_REMOVE:
                    begin
                        if (key_hit)
                        begin
                            found_next = 1'b1;
                            // Hit on the final entry: nothing to move down.
                            if (at_end)
                                count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            idx_next = idx_inc;
                        end
                    end
                    default:
                    begin
                        if (!list_stall)
                        begin
                            idx_next = idx_inc;
                            if (grp_hit)
                            begin
                                pend_next       = mem_rdata_reg;
                                pend_valid_next = 1'b1;
                            end
                        end
                    end
                endcase
            end
            ukt_pkg::ST_SHIFT_WR:
            begin
                idx_next = idx_inc;
                if (shift_end)
                    count_next = count_reg - CNT_W'(1);
            end
            ukt_pkg::ST_DONE:
            begin
                if (slot_free && do_insert)
                    count_next = count_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ukt_pkg::ST_IDLE;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            op_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        if (emit)
            out_reg <= emit_data;
    end

    assign cmd.ready              = (state_reg == ukt_pkg::ST_IDLE);
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_reg.status;
    assign rsp.out_key            = out_reg.out_key;
    assign rsp.out_group          = out_reg.out_group;
    assign rsp.out_name_handle    = out_reg.out_name_handle;
    assign rsp.out_surname_handle = out_reg.out_surname_handle;
    assign rsp.fill_level         = out_reg.fill_level;
    assign rsp.last               = out_reg.last;

endmodule

`default_nettype wire
